[hdl/pst_pkg.sv]
`timescale 1ns / 1ps
package pst_pkg;

    localparam int PROCESS_SLOTS_DEF   = 8;
    localparam int FDS_PER_PROCESS_DEF = 8;

    // Actions.
    localparam logic [2:0] ACT_CREATE = 3'd0;
    localparam logic [2:0] ACT_EXIT   = 3'd1;
    localparam logic [2:0] ACT_WAIT   = 3'd2;
    localparam logic [2:0] ACT_REAP   = 3'd3;
    localparam logic [2:0] ACT_QUERY  = 3'd4;
    localparam logic [2:0] ACT_OPEN   = 3'd5;
    localparam logic [2:0] ACT_READ   = 3'd6;
    localparam logic [2:0] ACT_CLOSE  = 3'd7;

    // Status codes.
    localparam logic [3:0] STS_OK        = 4'd0;
    localparam logic [3:0] STS_FULL      = 4'd1;
    localparam logic [3:0] STS_NO_CUR    = 4'd2;
    localparam logic [3:0] STS_PID_UNK   = 4'd3;
    localparam logic [3:0] STS_RUNNING   = 4'd4;
    localparam logic [3:0] STS_IDX_ABS   = 4'd5;
    localparam logic [3:0] STS_NO_FILE   = 4'd6;
    localparam logic [3:0] STS_NO_FD     = 4'd7;
    localparam logic [3:0] STS_BAD_FD    = 4'd8;
    localparam logic [3:0] STS_READ_FAIL = 4'd9;

    // Slot states.
    localparam logic [1:0] SL_UNUSED  = 2'd0;
    localparam logic [1:0] SL_RUNNING = 2'd1;
    localparam logic [1:0] SL_EXITED  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN2,
        S_FD_RD,
        S_FD_WR,
        S_DONE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture the input beat
        logic scan_clr;  // reset scan index
        logic scan_step; // visit one slot or descriptor
        logic pass2;     // second create pass (exited slots)
        logic fd_fetch;  // issue descriptor memory read
        logic commit;    // apply the update for the action
        logic emit;      // present the result
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last; // scan index at the final element
        logic hit;       // search has found its element
        logic early;     // action resolved without scan
        logic [2:0] action;
    } t_sts;

endpackage

[hdl/process_slot_table.sv]
`timescale 1ns / 1ps
// Channel   Ports                                  Direction
// command   i_start, o_busy, i_action ... i_bytes_done  in
// result    o_done, o_status ... o_current_pid     out
//
// A command beat is taken when i_start is high and o_busy is low; the next
// beat waits until the last result has been shown. The controller walks
// the slot table or the current process's descriptors one entry per cycle,
// and a descriptor read or close goes through states S_FD_RD and S_FD_WR.
// The result shows for one cycle on o_done and cannot be held off. Reset is
// synchronous and active low; no clearing pass is needed after it.
module process_slot_table #(
    parameter int PROCESS_SLOTS   = pst_pkg::PROCESS_SLOTS_DEF,
    parameter int FDS_PER_PROCESS = pst_pkg::FDS_PER_PROCESS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_entry_addr,
    input  logic [31:0] i_exit_value,
    input  logic [31:0] i_pid_query,
    input  logic [3:0]  i_visible_index,
    input  logic        i_file_found,
    input  logic [15:0] i_file_number,
    input  logic [3:0]  i_fd_number,
    input  logic        i_storage_ok,
    input  logic [15:0] i_bytes_done,
    output logic        o_done,
    output logic [3:0]  o_status,
    output logic [31:0] o_pid_out,
    output logic [2:0]  o_slot_out,
    output logic [1:0]  o_state_out,
    output logic [31:0] o_code_out,
    output logic [31:0] o_entry_out,
    output logic [3:0]  o_count_out,
    output logic [2:0]  o_fd_out,
    output logic [15:0] o_file_out,
    output logic [31:0] o_offset_out,
    output logic [31:0] o_current_pid
);

    pst_pkg::t_cmd cmd;
    pst_pkg::t_sts sts;

    // Sequencer.
    pst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Table and result datapath.
    pst_dp #(
        .PROCESS_SLOTS   (PROCESS_SLOTS),
        .FDS_PER_PROCESS (FDS_PER_PROCESS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_action),
        .i_entry_addr    (i_entry_addr),
        .i_exit_value    (i_exit_value),
        .i_pid_query     (i_pid_query),
        .i_visible_index (i_visible_index),
        .i_file_found    (i_file_found),
        .i_file_number   (i_file_number),
        .i_fd_number     (i_fd_number),
        .i_storage_ok    (i_storage_ok),
        .i_bytes_done    (i_bytes_done),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_pid_out       (o_pid_out),
        .o_slot_out      (o_slot_out),
        .o_state_out     (o_state_out),
        .o_code_out      (o_code_out),
        .o_entry_out     (o_entry_out),
        .o_count_out     (o_count_out),
        .o_fd_out        (o_fd_out),
        .o_file_out      (o_file_out),
        .o_offset_out    (o_offset_out),
        .o_current_pid   (o_current_pid)
    );

endmodule

[hdl/pst_ctrl.sv]
`timescale 1ns / 1ps
module pst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  pst_pkg::t_sts i_sts,
    output pst_pkg::t_cmd o_cmd
);

    pst_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != pst_pkg::S_IDLE);
        unique case (r_state)
            pst_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = pst_pkg::S_SCAN;
                end
            end
            pst_pkg::S_SCAN: begin
                if (i_sts.early) begin
                    n_state = pst_pkg::S_DONE;
                end else if (i_sts.action == pst_pkg::ACT_READ ||
                             i_sts.action == pst_pkg::ACT_CLOSE) begin
                    o_cmd.fd_fetch = 1'b1;
                    n_state        = pst_pkg::S_FD_RD;
                end else if (i_sts.hit) begin
                    n_state = pst_pkg::S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    if (i_sts.scan_last) begin
                        if (i_sts.action == pst_pkg::ACT_CREATE) begin
                            o_cmd.scan_clr = 1'b1;
                            o_cmd.pass2    = 1'b1;
                            n_state        = pst_pkg::S_SCAN2;
                        end else begin
                            n_state = pst_pkg::S_DONE;
                        end
                    end
                end
            end
            pst_pkg::S_SCAN2: begin
                if (i_sts.hit) begin
                    n_state = pst_pkg::S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    if (i_sts.scan_last) begin
                        n_state = pst_pkg::S_DONE;
                    end
                end
            end
            pst_pkg::S_FD_RD: begin
                n_state = pst_pkg::S_FD_WR;
            end
            pst_pkg::S_FD_WR: begin
                n_state = pst_pkg::S_DONE;
            end
            pst_pkg::S_DONE: begin
                o_cmd.commit = 1'b1;
                o_cmd.emit   = 1'b1;
                n_state      = pst_pkg::S_IDLE;
            end
            default: begin
                n_state = pst_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hdl/pst_dp.sv]
`timescale 1ns / 1ps
module pst_dp #(
    parameter int PROCESS_SLOTS   = pst_pkg::PROCESS_SLOTS_DEF,
    parameter int FDS_PER_PROCESS = pst_pkg::FDS_PER_PROCESS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pst_pkg::t_cmd i_cmd,
    output pst_pkg::t_sts o_sts,
    input  logic [2:0]    i_action,
    input  logic [31:0]   i_entry_addr,
    input  logic [31:0]   i_exit_value,
    input  logic [31:0]   i_pid_query,
    input  logic [3:0]    i_visible_index,
    input  logic          i_file_found,
    input  logic [15:0]   i_file_number,
    input  logic [3:0]    i_fd_number,
    input  logic          i_storage_ok,
    input  logic [15:0]   i_bytes_done,
    output logic          o_done,
    output logic [3:0]    o_status,
    output logic [31:0]   o_pid_out,
    output logic [2:0]    o_slot_out,
    output logic [1:0]    o_state_out,
    output logic [31:0]   o_code_out,
    output logic [31:0]   o_entry_out,
    output logic [3:0]    o_count_out,
    output logic [2:0]    o_fd_out,
    output logic [15:0]   o_file_out,
    output logic [31:0]   o_offset_out,
    output logic [31:0]   o_current_pid
);

    localparam int SW    = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
    localparam int FW    = (FDS_PER_PROCESS > 1) ? $clog2(FDS_PER_PROCESS) : 1;
    localparam int DT    = PROCESS_SLOTS * FDS_PER_PROCESS;
    localparam int DW    = SW + FW;
    localparam int CW    = $clog2(PROCESS_SLOTS + 1);
    localparam int IW    = (PROCESS_SLOTS > FDS_PER_PROCESS) ? SW : FW;

    // Slot table and descriptor state.
    logic [1:0]  r_slot_state [PROCESS_SLOTS];
    logic [31:0] r_slot_pid   [PROCESS_SLOTS];
    logic [31:0] r_slot_entry [PROCESS_SLOTS];
    logic [31:0] r_slot_code  [PROCESS_SLOTS];
    logic [DT-1:0] r_desc_open;
    logic [15:0] r_desc_file [DT];
    logic [31:0] r_desc_off  [DT];
    logic [31:0] r_pid_cnt;
    logic        r_cur_valid;
    logic [SW-1:0] r_cur_slot;
    logic [CW-1:0] r_occ;

    // Captured beat and working registers.
    logic [2:0]  r_act;
    logic [31:0] r_entry, r_exitv, r_pidq;
    logic [3:0]  r_vidx;
    logic        r_found, r_sok;
    logic [15:0] r_fnum, r_bytes;
    logic [3:0]  r_fd;
    logic [IW:0] r_idx;
    logic [3:0]  r_seen;
    logic        r_hit;
    logic [IW-1:0] r_pick;
    logic [CW-1:0] r_reaped;
    logic [15:0] r_rd_file;
    logic [31:0] r_rd_off;
    logic        r_pass2;

    logic [DW-1:0] cur_base;
    logic [DW-1:0] fd_addr;
    logic [DW-1:0] scan_daddr;
    logic [SW-1:0] sidx;
    logic          fd_ok;
    logic          visit_hit;

    assign sidx       = r_idx[SW-1:0];
    assign cur_base   = DW'(r_cur_slot) << FW;
    assign fd_addr    = cur_base + DW'(r_fd[FW-1:0]);
    assign scan_daddr = cur_base + DW'(r_idx[FW-1:0]);
    assign fd_ok      = r_cur_valid && ({28'd0, r_fd} < 32'(FDS_PER_PROCESS))
                        && r_desc_open[fd_addr];

    // Whether the element under the scan index is the one sought.
    always_comb begin
        visit_hit = 1'b0;
        unique case (r_act)
            pst_pkg::ACT_CREATE: visit_hit = r_pass2 ? 1'b0 :
                (r_slot_state[sidx] == pst_pkg::SL_UNUSED);
            pst_pkg::ACT_WAIT: visit_hit = (r_slot_state[sidx] != pst_pkg::SL_UNUSED) &&
                (r_slot_pid[sidx] == r_pidq);
            pst_pkg::ACT_QUERY: visit_hit = (r_slot_state[sidx] != pst_pkg::SL_UNUSED) &&
                (r_seen == r_vidx);
            pst_pkg::ACT_OPEN: visit_hit = !r_desc_open[scan_daddr];
            default: visit_hit = 1'b0;
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_sts.action = r_act;
        o_sts.hit    = r_hit;
        if (r_act == pst_pkg::ACT_OPEN) begin
            o_sts.scan_last = (r_idx == (IW+1)'(FDS_PER_PROCESS - 1));
        end else begin
            o_sts.scan_last = (r_idx == (IW+1)'(PROCESS_SLOTS - 1));
        end
        unique case (r_act)
            pst_pkg::ACT_EXIT:  o_sts.early = 1'b1;
            pst_pkg::ACT_OPEN:  o_sts.early = !r_cur_valid || !r_found;
            pst_pkg::ACT_READ,
            pst_pkg::ACT_CLOSE: o_sts.early = !fd_ok;
            default:            o_sts.early = 1'b0;
        endcase
    end

    // Capture, scan and descriptor fetch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_action;
            r_entry <= i_entry_addr;
            r_exitv <= i_exit_value;
            r_pidq  <= i_pid_query;
            r_vidx  <= i_visible_index;
            r_found <= i_file_found;
            r_fnum  <= i_file_number;
            r_fd    <= i_fd_number;
            r_sok   <= i_storage_ok;
            r_bytes <= i_bytes_done;
        end
        if (i_cmd.scan_clr) begin
            r_idx <= '0;
            if (i_cmd.load) begin
                r_seen   <= '0;
                r_hit    <= 1'b0;
                r_reaped <= '0;
            end
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.scan_step) begin
            if (r_act == pst_pkg::ACT_QUERY &&
                r_slot_state[sidx] != pst_pkg::SL_UNUSED) begin
                r_seen <= r_seen + 1'b1;
            end
            if (r_act == pst_pkg::ACT_REAP &&
                r_slot_state[sidx] == pst_pkg::SL_EXITED) begin
                r_reaped <= r_reaped + 1'b1;
            end
        end
        // Record the first element that matches the search.
        if (!r_hit && !i_cmd.load) begin
            if (i_cmd.scan_step && visit_hit) begin
                r_hit  <= 1'b1;
                r_pick <= r_idx[IW-1:0];
            end
        end
        if (i_cmd.fd_fetch) begin
            r_rd_file <= r_desc_file[fd_addr];
            r_rd_off  <= r_desc_off[fd_addr];
        end
    end

    // Second create pass flag: set when the unused pass ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_pass2 <= 1'b0;
        end else if (i_cmd.pass2) begin
            r_pass2 <= 1'b1;
        end
    end

    logic r_hit2;
    logic [SW-1:0] r_pick2;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit2 <= 1'b0;
        end else if (r_pass2 && !r_hit2 && i_cmd.scan_step &&
                     r_slot_state[sidx] == pst_pkg::SL_EXITED) begin
            r_hit2  <= 1'b1;
            r_pick2 <= sidx;
        end
    end

    // Create result selection.
    logic          cr_ok;
    logic [SW-1:0] cr_slot;
    assign cr_ok   = r_hit || r_hit2;
    assign cr_slot = r_hit ? r_pick[SW-1:0] : r_pick2;

    // Wait/query slot.
    logic [SW-1:0] fslot;
    assign fslot = r_pick[SW-1:0];

    // Commit of table updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PROCESS_SLOTS; i++) begin
                r_slot_state[i] <= pst_pkg::SL_UNUSED;
                r_slot_pid[i]   <= '0;
                r_slot_entry[i] <= '0;
                r_slot_code[i]  <= '0;
            end
            r_desc_open <= '0;
            r_pid_cnt   <= 32'd1;
            r_cur_valid <= 1'b0;
            r_cur_slot  <= '0;
            r_occ       <= '0;
        end else if (i_cmd.commit) begin
            unique case (r_act)
                pst_pkg::ACT_CREATE: begin
                    if (cr_ok) begin
                        if (r_slot_state[cr_slot] == pst_pkg::SL_UNUSED) begin
                            r_occ <= r_occ + 1'b1;
                        end
                        r_slot_state[cr_slot] <= pst_pkg::SL_RUNNING;
                        r_slot_pid[cr_slot]   <= r_pid_cnt;
                        r_slot_entry[cr_slot] <= r_entry;
                        r_slot_code[cr_slot]  <= '0;
                        for (int f = 0; f < FDS_PER_PROCESS; f++) begin
                            r_desc_open[(DW'(cr_slot) << FW) + DW'(f)] <= 1'b0;
                        end
                        r_pid_cnt   <= r_pid_cnt + 32'd1;
                        r_cur_valid <= 1'b1;
                        r_cur_slot  <= cr_slot;
                    end
                end
                pst_pkg::ACT_EXIT: begin
                    if (r_cur_valid) begin
                        r_slot_state[r_cur_slot] <= pst_pkg::SL_EXITED;
                        r_slot_code[r_cur_slot]  <= r_exitv;
                        for (int f = 0; f < FDS_PER_PROCESS; f++) begin
                            r_desc_open[cur_base + DW'(f)] <= 1'b0;
                        end
                        r_cur_valid <= 1'b0;
                    end
                end
                pst_pkg::ACT_REAP: begin
                    for (int i = 0; i < PROCESS_SLOTS; i++) begin
                        if (r_slot_state[i] == pst_pkg::SL_EXITED) begin
                            r_slot_state[i] <= pst_pkg::SL_UNUSED;
                            r_slot_pid[i]   <= '0;
                            r_slot_entry[i] <= '0;
                            r_slot_code[i]  <= '0;
                        end
                    end
                    r_occ <= r_occ - r_reaped;
                end
                pst_pkg::ACT_OPEN: begin
                    if (r_cur_valid && r_found && r_hit) begin
                        r_desc_open[cur_base + DW'(r_pick[FW-1:0])] <= 1'b1;
                    end
                end
                pst_pkg::ACT_CLOSE: begin
                    if (fd_ok) begin
                        r_desc_open[fd_addr] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Descriptor memory writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_act == pst_pkg::ACT_OPEN && r_cur_valid && r_found && r_hit) begin
                r_desc_file[cur_base + DW'(r_pick[FW-1:0])] <= r_fnum;
                r_desc_off[cur_base + DW'(r_pick[FW-1:0])]  <= '0;
            end else if (r_act == pst_pkg::ACT_READ && fd_ok && r_sok) begin
                r_desc_off[fd_addr] <= r_rd_off + {16'd0, r_bytes};
            end
        end
    end

    // Result register.
    logic [3:0]  n_status;
    logic [31:0] n_pid, n_code, n_entry, n_cur_pid;
    logic [2:0]  n_slot, n_fd;
    logic [1:0]  n_stt;
    logic [3:0]  n_count;
    logic [15:0] n_file;
    logic [31:0] n_off;

    always_comb begin
        n_status  = pst_pkg::STS_OK;
        n_pid     = '0;
        n_slot    = '0;
        n_stt     = '0;
        n_code    = '0;
        n_entry   = '0;
        n_count   = 4'(r_occ);
        n_fd      = '0;
        n_file    = '0;
        n_off     = '0;
        n_cur_pid = r_cur_valid ? r_slot_pid[r_cur_slot] : '0;
        unique case (r_act)
            pst_pkg::ACT_CREATE: begin
                if (cr_ok) begin
                    n_pid     = r_pid_cnt;
                    n_slot    = 3'(cr_slot);
                    n_cur_pid = r_pid_cnt;
                    if (r_slot_state[cr_slot] == pst_pkg::SL_UNUSED) begin
                        n_count = 4'(r_occ) + 4'd1;
                    end
                end else begin
                    n_status = pst_pkg::STS_FULL;
                end
            end
            pst_pkg::ACT_EXIT: begin
                if (r_cur_valid) begin
                    n_pid     = r_slot_pid[r_cur_slot];
                    n_slot    = 3'(r_cur_slot);
                    n_cur_pid = '0;
                end else begin
                    n_status = pst_pkg::STS_NO_CUR;
                end
            end
            pst_pkg::ACT_WAIT: begin
                if (!r_hit) begin
                    n_status = pst_pkg::STS_PID_UNK;
                end else begin
                    n_pid  = r_slot_pid[fslot];
                    n_slot = 3'(fslot);
                    n_stt  = r_slot_state[fslot];
                    if (r_slot_state[fslot] == pst_pkg::SL_EXITED) begin
                        n_code = r_slot_code[fslot];
                    end else begin
                        n_status = pst_pkg::STS_RUNNING;
                    end
                end
            end
            pst_pkg::ACT_REAP: begin
                n_count = 4'(r_reaped);
                if (r_cur_valid && r_slot_state[r_cur_slot] == pst_pkg::SL_EXITED) begin
                    n_cur_pid = '0;
                end
            end
            pst_pkg::ACT_QUERY: begin
                if (!r_hit) begin
                    n_status = pst_pkg::STS_IDX_ABS;
                end else begin
                    n_pid   = r_slot_pid[fslot];
                    n_slot  = 3'(fslot);
                    n_stt   = r_slot_state[fslot];
                    n_code  = r_slot_code[fslot];
                    n_entry = r_slot_entry[fslot];
                end
            end
            pst_pkg::ACT_OPEN: begin
                if (!r_cur_valid) begin
                    n_status = pst_pkg::STS_NO_CUR;
                end else if (!r_found) begin
                    n_status = pst_pkg::STS_NO_FILE;
                end else if (!r_hit) begin
                    n_status = pst_pkg::STS_NO_FD;
                end else begin
                    n_fd = 3'(r_pick[FW-1:0]);
                end
            end
            pst_pkg::ACT_READ, pst_pkg::ACT_CLOSE: begin
                if (!r_cur_valid) begin
                    n_status = pst_pkg::STS_NO_CUR;
                end else if (!fd_ok) begin
                    n_status = pst_pkg::STS_BAD_FD;
                end else if (r_act == pst_pkg::ACT_READ) begin
                    n_file = r_rd_file;
                    n_off  = r_rd_off;
                    if (!r_sok) begin
                        n_status = pst_pkg::STS_READ_FAIL;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            o_status      <= n_status;
            o_pid_out     <= n_pid;
            o_slot_out    <= n_slot;
            o_state_out   <= n_stt;
            o_code_out    <= n_code;
            o_entry_out   <= n_entry;
            o_count_out   <= n_count;
            o_fd_out      <= n_fd;
            o_file_out    <= n_file;
            o_offset_out  <= n_off;
            o_current_pid <= n_cur_pid;
        end
    end

endmodule

[tb/sv/process_slot_table_tb.sv]
`timescale 1ns / 1ps
module process_slot_table_tb;

    localparam int NSLOT    = pst_pkg::PROCESS_SLOTS_DEF;
    localparam int NFD      = pst_pkg::FDS_PER_PROCESS_DEF;
    localparam int WD_LIMIT = 4000;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] entry_addr;
        logic [31:0] exit_value;
        logic [31:0] pid_query;
        logic [3:0]  visible_index;
        logic        file_found;
        logic [15:0] file_number;
        logic [3:0]  fd_number;
        logic        storage_ok;
        logic [15:0] bytes_done;
    } t_call;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] pid;
        logic [2:0]  slot;
        logic [1:0]  state;
        logic [31:0] code;
        logic [31:0] entry;
        logic [3:0]  count;
        logic [2:0]  fd;
        logic [15:0] file;
        logic [31:0] offset;
        logic [31:0] cur_pid;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [2:0]  i_action;
    logic [31:0] i_entry_addr;
    logic [31:0] i_exit_value;
    logic [31:0] i_pid_query;
    logic [3:0]  i_visible_index;
    logic        i_file_found;
    logic [15:0] i_file_number;
    logic [3:0]  i_fd_number;
    logic        i_storage_ok;
    logic [15:0] i_bytes_done;
    logic        o_done;
    logic [3:0]  o_status;
    logic [31:0] o_pid_out;
    logic [2:0]  o_slot_out;
    logic [1:0]  o_state_out;
    logic [31:0] o_code_out;
    logic [31:0] o_entry_out;
    logic [3:0]  o_count_out;
    logic [2:0]  o_fd_out;
    logic [15:0] o_file_out;
    logic [31:0] o_offset_out;
    logic [31:0] o_current_pid;

    process_slot_table u_dut (.*);

    // Shadow copy of the process table.
    logic [1:0]  tbl_state [NSLOT];
    logic [31:0] tbl_pid   [NSLOT];
    logic [31:0] tbl_entry [NSLOT];
    logic [31:0] tbl_code  [NSLOT];
    logic        fd_is_open [NSLOT*NFD];
    logic [15:0] fd_file    [NSLOT*NFD];
    logic [31:0] fd_offset  [NSLOT*NFD];
    logic [31:0] shadow_pid_cnt;
    logic        has_cur;
    logic [2:0]  cur_slot;

    t_reply pending_replies[$];
    int     fail_count;
    int     idle_cycles;
    bit     accepted;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int occupied();
        int n;
        n = 0;
        for (int i = 0; i < NSLOT; i++) if (tbl_state[i] != pst_pkg::SL_UNUSED) n++;
        return n;
    endfunction

    // Compute the reply for one call and update the shadow table.
    function automatic t_reply apply_call(t_call c);
        t_reply r;
        int     pick;
        int     seen;
        int     d;
        bit     count_done;
        r = '0;
        count_done = 1'b0;
        pick = -1;
        case (c.action)
            pst_pkg::ACT_CREATE: begin
                for (int i = 0; i < NSLOT; i++)
                    if (pick < 0 && tbl_state[i] == pst_pkg::SL_UNUSED) pick = i;
                for (int i = 0; i < NSLOT; i++)
                    if (pick < 0 && tbl_state[i] == pst_pkg::SL_EXITED) pick = i;
                if (pick < 0) begin
                    r.status = pst_pkg::STS_FULL;
                end else begin
                    tbl_pid[pick] = shadow_pid_cnt;
                    shadow_pid_cnt = shadow_pid_cnt + 32'd1;
                    tbl_state[pick] = pst_pkg::SL_RUNNING;
                    tbl_entry[pick] = c.entry_addr;
                    tbl_code[pick] = '0;
                    for (int f = 0; f < NFD; f++) begin
                        fd_is_open[pick*NFD+f] = 1'b0;
                        fd_file[pick*NFD+f] = '0;
                        fd_offset[pick*NFD+f] = '0;
                    end
                    has_cur = 1'b1;
                    cur_slot = 3'(pick);
                    r.pid = tbl_pid[pick];
                    r.slot = 3'(pick);
                end
            end
            pst_pkg::ACT_EXIT: begin
                if (!has_cur) begin
                    r.status = pst_pkg::STS_NO_CUR;
                end else begin
                    tbl_code[cur_slot] = c.exit_value;
                    tbl_state[cur_slot] = pst_pkg::SL_EXITED;
                    for (int f = 0; f < NFD; f++) fd_is_open[cur_slot*NFD+f] = 1'b0;
                    has_cur = 1'b0;
                    r.pid = tbl_pid[cur_slot];
                    r.slot = cur_slot;
                end
            end
            pst_pkg::ACT_WAIT: begin
                r.status = pst_pkg::STS_PID_UNK;
                for (int i = 0; i < NSLOT; i++)
                    if (pick < 0 && tbl_state[i] != pst_pkg::SL_UNUSED &&
                        tbl_pid[i] == c.pid_query)
                        pick = i;
                if (pick >= 0) begin
                    r.pid = tbl_pid[pick];
                    r.slot = 3'(pick);
                    r.state = tbl_state[pick];
                    if (tbl_state[pick] == pst_pkg::SL_EXITED) begin
                        r.status = pst_pkg::STS_OK;
                        r.code = tbl_code[pick];
                    end else begin
                        r.status = pst_pkg::STS_RUNNING;
                    end
                end
            end
            pst_pkg::ACT_REAP: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (tbl_state[i] == pst_pkg::SL_EXITED) begin
                        tbl_state[i] = pst_pkg::SL_UNUSED;
                        tbl_pid[i] = '0;
                        tbl_entry[i] = '0;
                        tbl_code[i] = '0;
                        r.count = r.count + 4'd1;
                    end
                end
                count_done = 1'b1;
            end
            pst_pkg::ACT_QUERY: begin
                seen = 0;
                r.status = pst_pkg::STS_IDX_ABS;
                for (int i = 0; i < NSLOT; i++) begin
                    if (pick < 0 && tbl_state[i] != pst_pkg::SL_UNUSED) begin
                        if (seen == int'(c.visible_index)) begin
                            pick = i;
                            r.status = pst_pkg::STS_OK;
                            r.pid = tbl_pid[i];
                            r.slot = 3'(i);
                            r.state = tbl_state[i];
                            r.code = tbl_code[i];
                            r.entry = tbl_entry[i];
                        end
                        seen++;
                    end
                end
            end
            pst_pkg::ACT_OPEN: begin
                if (!has_cur) r.status = pst_pkg::STS_NO_CUR;
                else if (!c.file_found) r.status = pst_pkg::STS_NO_FILE;
                else begin
                    r.status = pst_pkg::STS_NO_FD;
                    for (int f = 0; f < NFD; f++) begin
                        d = cur_slot*NFD + f;
                        if (pick < 0 && !fd_is_open[d]) begin
                            pick = f;
                            fd_is_open[d] = 1'b1;
                            fd_file[d] = c.file_number;
                            fd_offset[d] = '0;
                            r.fd = 3'(f);
                            r.status = pst_pkg::STS_OK;
                        end
                    end
                end
            end
            default: begin
                // Descriptor read and close share their checks.
                d = cur_slot*NFD + c.fd_number;
                if (!has_cur) r.status = pst_pkg::STS_NO_CUR;
                else if (c.fd_number >= NFD || !fd_is_open[d]) r.status = pst_pkg::STS_BAD_FD;
                else if (c.action == pst_pkg::ACT_CLOSE) fd_is_open[d] = 1'b0;
                else begin
                    r.file = fd_file[d];
                    r.offset = fd_offset[d];
                    if (!c.storage_ok) r.status = pst_pkg::STS_READ_FAIL;
                    else fd_offset[d] = fd_offset[d] + {16'd0, c.bytes_done};
                end
            end
        endcase
        if (!count_done) r.count = 4'(occupied());
        r.cur_pid = has_cur ? tbl_pid[cur_slot] : '0;
        return r;
    endfunction

    // Send one command beat after a random gap; returns at a falling edge.
    task automatic send_call(t_call c);
        int gap;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action = c.action;
        i_entry_addr = c.entry_addr;
        i_exit_value = c.exit_value;
        i_pid_query = c.pid_query;
        i_visible_index = c.visible_index;
        i_file_found = c.file_found;
        i_file_number = c.file_number;
        i_fd_number = c.fd_number;
        i_storage_ok = c.storage_ok;
        i_bytes_done = c.bytes_done;
        i_start = 1'b1;
        // Busy only changes at rising edges, so look at it between them.
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        accepted = 1'b1;
        pending_replies.push_back(apply_call(c));
        @(negedge i_clk);
        accepted = 1'b0;
        i_start = 1'b0;
    endtask

    function automatic t_call random_call();
        t_call c;
        c.action = 3'($urandom_range(0, 7));
        c.entry_addr = $urandom;
        c.exit_value = $urandom;
        c.pid_query = $urandom;
        c.visible_index = 4'($urandom_range(0, 15));
        c.file_found = 1'($urandom_range(0, 1));
        c.file_number = 16'($urandom);
        c.fd_number = 4'($urandom_range(0, 15));
        c.storage_ok = 1'($urandom_range(0, 1));
        c.bytes_done = 16'($urandom);
        return c;
    endfunction

    task automatic do_call(logic [2:0] act, logic [31:0] arg = 32'd0, logic flag = 1'b1,
                           logic [15:0] amount = 16'd0);
        t_call c;
        c = random_call();
        c.action = act;
        c.file_found = flag;
        c.storage_ok = flag;
        case (act)
            pst_pkg::ACT_CREATE: c.entry_addr = arg;
            pst_pkg::ACT_EXIT:   c.exit_value = arg;
            pst_pkg::ACT_WAIT:   c.pid_query = arg;
            pst_pkg::ACT_QUERY:  c.visible_index = arg[3:0];
            pst_pkg::ACT_OPEN:   c.file_number = arg[15:0];
            default:             c.fd_number = arg[3:0];
        endcase
        if (act == pst_pkg::ACT_READ) c.bytes_done = amount;
        send_call(c);
    endtask

    // Hold the sender until every expected reply is in.
    task automatic drain();
        while (pending_replies.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Every call but create on an empty table.
    task automatic test_empty_table();
        do_call(pst_pkg::ACT_EXIT, 32'h1234);
        do_call(pst_pkg::ACT_OPEN, 32'h0001);
        do_call(pst_pkg::ACT_READ, 32'd0, 1'b1, 16'h10);
        do_call(pst_pkg::ACT_CLOSE, 32'd0);
        do_call(pst_pkg::ACT_WAIT, 32'h0);
        do_call(pst_pkg::ACT_QUERY, 32'd0);
        do_call(pst_pkg::ACT_REAP);
        drain();
    endtask

    // Fill every slot, overflow, then wait and query the extremes.
    task automatic test_full_table();
        do_call(pst_pkg::ACT_CREATE, 32'h0);
        do_call(pst_pkg::ACT_CREATE, 32'hFFFF_FFFF);
        for (int i = 0; i < NSLOT - 2; i++) do_call(pst_pkg::ACT_CREATE, $urandom);
        do_call(pst_pkg::ACT_CREATE, 32'hDEAD_BEEF);
        do_call(pst_pkg::ACT_WAIT, 32'd1);
        do_call(pst_pkg::ACT_WAIT, 32'hFFFF_FFFF);
        do_call(pst_pkg::ACT_QUERY, 32'd7);
        do_call(pst_pkg::ACT_QUERY, 32'd15);
        drain();
    endtask

    // Descriptor open, read, close and their failures on the current process.
    task automatic test_descriptors();
        do_call(pst_pkg::ACT_OPEN, 32'hFFFF, 1'b0);
        for (int f = 0; f <= NFD; f++)
            do_call(pst_pkg::ACT_OPEN, (f == 0) ? 32'h0000_FFFF : 32'(f));
        do_call(pst_pkg::ACT_READ, 32'd0, 1'b1, 16'hFFFF);
        do_call(pst_pkg::ACT_READ, 32'd0, 1'b1, 16'h0);
        do_call(pst_pkg::ACT_READ, 32'd0, 1'b0, 16'h55);
        do_call(pst_pkg::ACT_READ, 32'd8);
        do_call(pst_pkg::ACT_CLOSE, 32'd15);
        do_call(pst_pkg::ACT_CLOSE, 32'd3);
        do_call(pst_pkg::ACT_READ, 32'd3);
        do_call(pst_pkg::ACT_CLOSE, 32'd3);
        do_call(pst_pkg::ACT_OPEN, 32'h0042);
        drain();
    endtask

    // Exit, wait on exited and running pids, reap, reuse.
    task automatic test_lifecycle();
        do_call(pst_pkg::ACT_EXIT, 32'h8000_0000);
        do_call(pst_pkg::ACT_WAIT, 32'd8);
        do_call(pst_pkg::ACT_WAIT, 32'd2);
        do_call(pst_pkg::ACT_CREATE, 32'h1000);
        do_call(pst_pkg::ACT_EXIT, 32'h7FFF_FFFF);
        do_call(pst_pkg::ACT_REAP);
        do_call(pst_pkg::ACT_REAP);
        do_call(pst_pkg::ACT_CREATE, 32'h2000);
        do_call(pst_pkg::ACT_EXIT, 32'hFFFF_FFFF);
        drain();
    endtask

    // Mostly well-formed calls aimed at pids in the table and in-range descriptors.
    task automatic test_random(int n_calls);
        t_call c;
        int    r;
        int    s;
        for (int k = 0; k < n_calls; k++) begin
            c = random_call();
            r = $urandom_range(0, 99);
            if (r < 15) c.action = pst_pkg::ACT_CREATE;
            else if (r < 24) c.action = pst_pkg::ACT_EXIT;
            else if (r < 36) c.action = pst_pkg::ACT_WAIT;
            else if (r < 41) c.action = pst_pkg::ACT_REAP;
            else if (r < 50) c.action = pst_pkg::ACT_QUERY;
            else if (r < 66) c.action = pst_pkg::ACT_OPEN;
            else if (r < 88) c.action = pst_pkg::ACT_READ;
            else c.action = pst_pkg::ACT_CLOSE;
            if (!has_cur && $urandom_range(0, 1) == 0) c.action = pst_pkg::ACT_CREATE;
            if ($urandom_range(0, 9) < 7) begin
                s = $urandom_range(0, NSLOT - 1);
                c.pid_query = tbl_pid[s];
            end
            if ($urandom_range(0, 9) < 8) c.fd_number = 4'($urandom_range(0, NFD - 1));
            if ($urandom_range(0, 9) < 8) c.file_found = 1'b1;
            if ($urandom_range(0, 9) < 8) c.storage_ok = 1'b1;
            if ($urandom_range(0, 9) < 6) c.visible_index = 4'($urandom_range(0, 8));
            send_call(c);
            if (k % 300 == 150) drain();
        end
    endtask

    // Compare each reply with the oldest prediction.
    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_reply e;
        if (i_rst_n && o_done) begin
            if (pending_replies.size() == 0) begin
                $error("reply with no call outstanding");
                fail_count++;
            end else begin
                e = pending_replies.pop_front();
                check_field("status", 32'(e.status), 32'(o_status));
                check_field("pid_out", e.pid, o_pid_out);
                check_field("slot_out", 32'(e.slot), 32'(o_slot_out));
                check_field("state_out", 32'(e.state), 32'(o_state_out));
                check_field("code_out", e.code, o_code_out);
                check_field("entry_out", e.entry, o_entry_out);
                check_field("count_out", 32'(e.count), 32'(o_count_out));
                check_field("fd_out", 32'(e.fd), 32'(o_fd_out));
                check_field("file_out", 32'(e.file), 32'(o_file_out));
                check_field("offset_out", e.offset, o_offset_out);
                check_field("current_pid", e.cur_pid, o_current_pid);
            end
        end
    end

    // Watchdog on cycles with no beat in either direction.
    always @(posedge i_clk) begin
        if (accepted || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("process_slot_table_tb NOT OK");
            $finish;
        end
    end

    initial begin
        fail_count = 0;
        idle_cycles = 0;
        accepted = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_state[i] = pst_pkg::SL_UNUSED;
            tbl_pid[i] = '0;
            tbl_entry[i] = '0;
            tbl_code[i] = '0;
        end
        for (int d = 0; d < NSLOT*NFD; d++) begin
            fd_is_open[d] = 1'b0;
            fd_file[d] = '0;
            fd_offset[d] = '0;
        end
        shadow_pid_cnt = 32'd1;
        has_cur = 1'b0;
        cur_slot = '0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_action = pst_pkg::ACT_CREATE;
        i_entry_addr = '0;
        i_exit_value = '0;
        i_pid_query = '0;
        i_visible_index = '0;
        i_file_found = 1'b0;
        i_file_number = '0;
        i_fd_number = '0;
        i_storage_ok = 1'b0;
        i_bytes_done = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_full_table();
        test_descriptors();
        test_lifecycle();
        test_random(1100);

        i_start = 1'b0;
        drain();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending_replies.size() == 0) begin
            $display("process_slot_table_tb OK");
        end else begin
            $display("process_slot_table_tb NOT OK");
        end
        $finish;
    end

endmodule
